// ----- src/analog_to_logic_classifier_top_macros.svh -----
// assertion macros shared by the classifier rtl
`ifndef ANALOG_TO_LOGIC_CLASSIFIER_TOP_MACROS_SVH
`define ANALOG_TO_LOGIC_CLASSIFIER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, off while in reset
`define ACL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while in reset
`define ACL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ACL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ACL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- src/acl_pkg.sv -----
package acl_pkg;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int TIME_W   = 16;
   localparam int LIMIT_W  = 16;
   localparam int MARGIN_W = 14;
   localparam int QUAL_W   = 4;
   localparam int LV_W     = 3;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int FS_SHIFT = 14;

   typedef logic [LV_W-1:0]         lv_type;
   typedef logic [QUAL_W-1:0]       qual_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [2:0]              reg_index_type;

   // logic state codes
   localparam lv_type LV_S0   = 3'd0;
   localparam lv_type LV_RISE = 3'd1;
   localparam lv_type LV_FALL = 3'd2;
   localparam lv_type LV_S1   = 3'd3;
   localparam lv_type LV_UNK  = 3'd4;

   // full scale in q2.14
   localparam logic signed [SAMPLE_W+1:0] FULL_SCALE = 18'sd16384;

   // register indexes
   localparam reg_index_type REG_THRESH_HIGH = 3'd0;
   localparam reg_index_type REG_THRESH_LOW  = 3'd1;
   localparam reg_index_type REG_RISE_LIMIT  = 3'd2;
   localparam reg_index_type REG_FALL_LIMIT  = 3'd3;
   localparam reg_index_type REG_OVER_MARGIN = 3'd4;
   localparam reg_index_type REG_GOOD_LEVEL  = 3'd5;

   // register reset values
   localparam sample_type            RST_THRESH_HIGH = 16'sd11469;
   localparam sample_type            RST_THRESH_LOW  = 16'sd4915;
   localparam logic [LIMIT_W-1:0]    RST_RISE_LIMIT  = 16'd100;
   localparam logic [LIMIT_W-1:0]    RST_FALL_LIMIT  = 16'd100;
   localparam logic [MARGIN_W-1:0]   RST_OVER_MARGIN = 14'd1638;
   localparam qual_type              RST_GOOD_LEVEL  = 4'd2;
   localparam qual_type              QUAL_BAD        = 4'd0;

   // stable state entered from a transition, from the other stable state or from unknown
   function automatic logic is_stable_entry(input lv_type from_lv, input lv_type to_lv);
      logic res;
      res = 1'b0;
      if (to_lv == LV_S1) begin
         res = (from_lv == LV_S0) || (from_lv == LV_RISE) || (from_lv == LV_UNK);
      end else if (to_lv == LV_S0) begin
         res = (from_lv == LV_FALL) || (from_lv == LV_S1) || (from_lv == LV_UNK);
      end
      return res;
   endfunction

endpackage

// ----- src/acl_if.sv -----
// sample item channel
interface acl_req_if;
   import acl_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SAMPLE_W-1:0] prev_sample;
   logic [TIME_W-1:0]          elapsed_time;
   logic                       restart;

   modport source (output valid, sample, prev_sample, elapsed_time, restart, input ready);
   modport sink (input valid, sample, prev_sample, elapsed_time, restart, output ready);
endinterface

// classification item channel
interface acl_rsp_if;
   import acl_pkg::*;

   logic              valid;
   logic              ready;
   logic [LV_W-1:0]   logic_value;
   logic [QUAL_W-1:0] quality_value;
   logic              became_stable;
   logic              out_of_range;

   modport source (output valid, logic_value, quality_value, became_stable, out_of_range,
                   input ready);
   modport sink (input valid, logic_value, quality_value, became_stable, out_of_range,
                 output ready);
endinterface

// ----- src/analog_to_logic_classifier_top.sv -----
// datapath: an accepted item passes through the input register and then the result
//   register, and either of them can be held while the result side stalls
// throughput: one item per cycle while the result side is not stalled, set by the
//   state update loop (threshold compare, one 16x16 slope multiply, quality update)
// reset: synchronous, active high; logic state goes unknown, quality bad,
//   registers to their defaults, both pipeline stages empty
`include "analog_to_logic_classifier_top_macros.svh"

module analog_to_logic_classifier_top (
   input  logic                        clock,
   input  logic                        reset,
   acl_req_if.sink                     req_chan,
   acl_rsp_if.source                   rsp_chan,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [acl_pkg::ADDR_W-1:0]  paddr,
   input  logic [acl_pkg::DATA_W-1:0]  pwdata,
   output logic [acl_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import acl_pkg::*;

   // configuration registers
   sample_type            thresh_high_ff;
   sample_type            thresh_low_ff;
   logic [LIMIT_W-1:0]    rise_limit_ff;
   logic [LIMIT_W-1:0]    fall_limit_ff;
   logic [MARGIN_W-1:0]   over_margin_ff;
   qual_type              good_level_ff;

   // classifier state
   lv_type                logic_state_ff;
   qual_type              quality_ff;

   // input stage
   logic                  s1_valid_ff;
   sample_type            s1_sample_ff;
   sample_type            s1_prev_ff;
   logic [TIME_W-1:0]     s1_time_ff;
   logic                  s1_restart_ff;

   // result stage
   logic                  rsp_valid_ff;
   lv_type                rsp_logic_ff;
   qual_type              rsp_qual_ff;
   logic                  rsp_stable_ff;
   logic                  rsp_oor_ff;

   // next values from the classifier
   lv_type                logic_state_in;
   qual_type              quality_in;
   logic                  stable_in;
   logic                  oor_in;

   logic                  rsp_adv;
   logic                  s1_adv;
   logic                  req_take;
   logic                  csr_write;
   reg_index_type         csr_index;

   // handshake
   assign rsp_adv        = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && rsp_adv;
   assign req_chan.ready = !s1_valid_ff || rsp_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   // configuration port
   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_high_ff <= RST_THRESH_HIGH;
         thresh_low_ff  <= RST_THRESH_LOW;
         rise_limit_ff  <= RST_RISE_LIMIT;
         fall_limit_ff  <= RST_FALL_LIMIT;
         over_margin_ff <= RST_OVER_MARGIN;
         good_level_ff  <= RST_GOOD_LEVEL;
      end else if (csr_write) begin
         case (csr_index)
            REG_THRESH_HIGH: thresh_high_ff <= pwdata[SAMPLE_W-1:0];
            REG_THRESH_LOW:  thresh_low_ff  <= pwdata[SAMPLE_W-1:0];
            REG_RISE_LIMIT:  rise_limit_ff  <= pwdata[LIMIT_W-1:0];
            REG_FALL_LIMIT:  fall_limit_ff  <= pwdata[LIMIT_W-1:0];
            REG_OVER_MARGIN: over_margin_ff <= pwdata[MARGIN_W-1:0];
            REG_GOOD_LEVEL:  good_level_ff  <= pwdata[QUAL_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_THRESH_HIGH: prdata = {{(DATA_W-SAMPLE_W){1'b0}}, thresh_high_ff};
         REG_THRESH_LOW:  prdata = {{(DATA_W-SAMPLE_W){1'b0}}, thresh_low_ff};
         REG_RISE_LIMIT:  prdata = {{(DATA_W-LIMIT_W){1'b0}}, rise_limit_ff};
         REG_FALL_LIMIT:  prdata = {{(DATA_W-LIMIT_W){1'b0}}, fall_limit_ff};
         REG_OVER_MARGIN: prdata = {{(DATA_W-MARGIN_W){1'b0}}, over_margin_ff};
         REG_GOOD_LEVEL:  prdata = {{(DATA_W-QUAL_W){1'b0}}, good_level_ff};
         default:         prdata = '0;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_sample_ff  <= req_chan.sample;
         s1_prev_ff    <= req_chan.prev_sample;
         s1_time_ff    <= req_chan.elapsed_time;
         s1_restart_ff <= req_chan.restart;
      end
   end

   // classification of the item in the input register
   always_comb begin
      lv_type                       prior;
      lv_type                       lv;
      qual_type                     q;
      logic signed [SAMPLE_W:0]     diff;
      logic [SAMPLE_W-1:0]          diff_abs;
      logic [LIMIT_W-1:0]           limit;
      logic [2*LIMIT_W-1:0]         prod;
      logic [2*LIMIT_W-1:0]         scaled_dt;
      logic                         slow;
      logic signed [SAMPLE_W+1:0]   sv_wide;
      logic signed [SAMPLE_W+1:0]   margin_wide;

      prior     = s1_restart_ff ? LV_UNK : logic_state_ff;
      lv        = prior;
      q         = quality_ff;

      // slope test: one multiply against elapsed ticks times full scale
      diff      = {s1_sample_ff[SAMPLE_W-1], s1_sample_ff} - {s1_prev_ff[SAMPLE_W-1], s1_prev_ff};
      diff_abs  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
      limit     = diff[SAMPLE_W] ? fall_limit_ff : rise_limit_ff;
      prod      = diff_abs * limit;
      scaled_dt = {{(2*LIMIT_W-TIME_W-FS_SHIFT){1'b0}}, s1_time_ff, {FS_SHIFT{1'b0}}};
      slow      = prod < scaled_dt;

      if (s1_sample_ff >= thresh_high_ff) begin
         if (prior == LV_FALL) begin
            q = QUAL_BAD;
         end else if (prior == LV_UNK) begin
            q = good_level_ff;
         end
         lv = LV_S1;
      end else if (s1_sample_ff <= thresh_low_ff) begin
         if (prior == LV_RISE) begin
            q = QUAL_BAD;
         end else if (prior == LV_UNK) begin
            q = good_level_ff;
         end
         lv = LV_S0;
      end else if (diff > 0) begin
         if (prior == LV_RISE) begin
            if (slow) q = QUAL_BAD;
         end else if (prior != LV_S0) begin
            q = QUAL_BAD;
         end
         lv = LV_RISE;
      end else if (diff < 0) begin
         if (prior == LV_FALL) begin
            if (slow) q = QUAL_BAD;
         end else if (prior != LV_S1) begin
            q = QUAL_BAD;
         end
         lv = LV_FALL;
      end else begin
         // flat in the transition region
         q = QUAL_BAD;
      end

      // range check against zero and full scale widened by the margin
      sv_wide     = {{2{s1_sample_ff[SAMPLE_W-1]}}, s1_sample_ff};
      margin_wide = {{(SAMPLE_W+2-MARGIN_W){1'b0}}, over_margin_ff};
      oor_in      = (sv_wide > (FULL_SCALE + margin_wide)) || (sv_wide < -margin_wide);
      if (oor_in) q = QUAL_BAD;

      // stable entry raises quality up to the good level
      stable_in = is_stable_entry(prior, lv);
      if (stable_in && (q < good_level_ff)) q = q + 4'd1;

      logic_state_in = lv;
      quality_in     = q;
   end

   // state update as the item leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         logic_state_ff <= LV_UNK;
         quality_ff     <= QUAL_BAD;
      end else if (s1_adv) begin
         logic_state_ff <= logic_state_in;
         quality_ff     <= quality_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_logic_ff  <= logic_state_in;
         rsp_qual_ff   <= quality_in;
         rsp_stable_ff <= stable_in;
         rsp_oor_ff    <= oor_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.logic_value   = rsp_logic_ff;
   assign rsp_chan.quality_value = rsp_qual_ff;
   assign rsp_chan.became_stable = rsp_stable_ff;
   assign rsp_chan.out_of_range  = rsp_oor_ff;

   // checks
   `ACL_ASSERT_NEXT(state_tracks_result, clock, reset, s1_adv,
      (logic_state_ff == rsp_logic_ff) && (quality_ff == rsp_qual_ff))
   `ACL_ASSERT_IMPLY(oor_keeps_quality_low, clock, reset, rsp_valid_ff && rsp_oor_ff,
      rsp_qual_ff <= 4'd1)
   `ACL_ASSERT_IMPLY(stable_entry_is_stable, clock, reset, rsp_valid_ff && rsp_stable_ff,
      (rsp_logic_ff == LV_S0) || (rsp_logic_ff == LV_S1))
   `ACL_ASSERT_IMPLY(unknown_needs_flat_restart, clock, reset,
      rsp_valid_ff && (rsp_logic_ff == LV_UNK), rsp_qual_ff == QUAL_BAD)

endmodule
